// ===== hdl/ofw_pkg.sv =====
// Shared types and constants for the overlapped frame windowing unit.
package ofw_pkg;

	localparam int HOP_LIMIT = 1024;
	localparam int CFG_W     = 11;
	localparam int SMP_W     = 16;
	localparam int COEF_W    = 16;
	localparam int IDX_W     = 10;
	localparam int FN_W      = 16;
	localparam int POS_W     = 10;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	localparam logic REG_FRAME_LENGTH = 1'b0;
	localparam logic REG_HOP          = 1'b1;

	localparam logic [CFG_W-1:0] FRAME_LENGTH_RST = 11'd480;
	localparam logic [CFG_W-1:0] HOP_RST          = 11'd160;

	typedef struct packed {
		logic                     command;
		logic signed [SMP_W-1:0]  sample;
		logic [IDX_W-1:0]         coef_index;
		logic [COEF_W-1:0]        coef_value;
	} in_t;

	typedef struct packed {
		logic [FN_W-1:0]          frame_number;
		logic [POS_W-1:0]         position;
		logic signed [SMP_W-1:0]  windowed_value;
		logic                     last;
	} out_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [CFG_W-1:0] flen;
		logic [CFG_W-1:0] hop;
	} cfg_t;

	// one multiply request from the sequencer
	typedef struct packed {
		logic                     valid;
		logic signed [SMP_W-1:0]  sample;
		logic [FN_W-1:0]          frame_number;
		logic [POS_W-1:0]         position;
		logic                     last;
	} iss_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_INIT,
		SEQ_RUN
	} seq_state_t;

endpackage

// ===== hdl/ofw_coef_ram.sv =====
// Window coefficient memory: one write port, one registered read port.
module ofw_coef_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [ofw_pkg::COEF_W-1:0]    wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [ofw_pkg::COEF_W-1:0]    rdata
);

	logic [ofw_pkg::COEF_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/ofw_seq.sv =====
// Frame sequencer: hop tracking, frame counters and per-frame read issue.
module ofw_seq #(
	parameter int FRAME_MAX   = 1024,
	parameter int MAX_OVERLAP = 8,
	parameter int AW          = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ofw_pkg::in_t        in_data,
	output logic                busy,
	input  ofw_pkg::cfg_t       cfg,
	input  logic                adv,
	output ofw_pkg::iss_t       issue,
	output logic [AW-1:0]       raddr,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [ofw_pkg::COEF_W-1:0] wr_data
);

	localparam int FSW = $clog2(MAX_OVERLAP + 1);
	localparam int PW  = $clog2(MAX_OVERLAP * ofw_pkg::HOP_LIMIT);
	localparam int MW  = FSW + ofw_pkg::CFG_W + 1;

	ofw_pkg::seq_state_t state_q, state_d;

	logic [ofw_pkg::IDX_W-1:0]        off_q;
	logic [ofw_pkg::IDX_W-1:0]        cur_off_q;
	logic [ofw_pkg::FN_W-1:0]         fc_q;
	logic [FSW-1:0]                   fs_q;
	logic [FSW-1:0]                   cnt_q;
	logic [PW-1:0]                    pos_q;
	logic [ofw_pkg::FN_W-1:0]         fn_q;
	logic signed [ofw_pkg::SMP_W-1:0] smp_q;

	logic                             accept;
	logic                             take_sample;
	logic [ofw_pkg::IDX_W-1:0]        off_c;
	logic [ofw_pkg::CFG_W-1:0]        off_nxt;
	logic [FSW-1:0]                   fsm1;
	logic [MW-1:0]                    pos_init;
	logic                             hit;
	logic                             step;

	assign busy        = (state_q != ofw_pkg::SEQ_IDLE);
	assign accept      = in_valid && !busy;
	assign take_sample = accept && (in_data.command == ofw_pkg::CMD_SAMPLE);

	assign wr_en   = accept && (in_data.command == ofw_pkg::CMD_LOAD)
		&& (32'(in_data.coef_index) < FRAME_MAX);
	assign wr_addr = AW'(in_data.coef_index);
	assign wr_data = in_data.coef_value;

	assign off_c    = (ofw_pkg::CFG_W'(off_q) >= cfg.hop) ? '0 : off_q;
	assign off_nxt  = ofw_pkg::CFG_W'(off_c) + 1'b1;
	assign fsm1     = fs_q - 1'b1;
	assign pos_init = MW'(cur_off_q) + MW'(fsm1) * MW'(cfg.hop);

	assign hit   = (32'(pos_q) < 32'(cfg.flen));
	assign raddr = AW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ofw_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d               = state_q;
		step                  = 1'b0;
		issue.valid           = 1'b0;
		issue.sample          = smp_q;
		issue.frame_number    = fn_q;
		issue.position        = pos_q[ofw_pkg::POS_W-1:0];
		issue.last            = (cnt_q == FSW'(1));
		case (state_q)
			ofw_pkg::SEQ_IDLE: begin
				if (take_sample) begin
					state_d = ofw_pkg::SEQ_INIT;
				end
			end
			ofw_pkg::SEQ_INIT: begin
				state_d = ofw_pkg::SEQ_RUN;
			end
			ofw_pkg::SEQ_RUN: begin
				step        = !hit || adv;
				issue.valid = hit && adv;
				if (step && (cnt_q == FSW'(1))) begin
					state_d = ofw_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = ofw_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			fc_q  <= '0;
			fs_q  <= '0;
		end else if (take_sample) begin
			off_q <= (off_nxt >= cfg.hop) ? '0 : off_nxt[ofw_pkg::IDX_W-1:0];
			if (off_c == '0) begin
				if (fs_q != '0) begin
					fc_q <= fc_q + 1'b1;
				end
				if (32'(fs_q) < MAX_OVERLAP) begin
					fs_q <= fs_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample) begin
			cur_off_q <= off_c;
			smp_q     <= in_data.sample;
		end
		if (state_q == ofw_pkg::SEQ_INIT) begin
			pos_q <= PW'(pos_init);
			fn_q  <= fc_q - ofw_pkg::FN_W'(fsm1);
			cnt_q <= fs_q;
		end else if (step) begin
			pos_q <= pos_q - PW'(cfg.hop);
			fn_q  <= fn_q + 1'b1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/ofw_mac.sv =====
// Coefficient read, multiply, round and saturate, output register.
module ofw_mac #(
	parameter int FRAME_MAX = 1024,
	parameter int AW        = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ofw_pkg::iss_t              issue,
	input  logic [AW-1:0]              raddr,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [ofw_pkg::COEF_W-1:0] wr_data,
	output logic                       adv,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ofw_pkg::out_t              out_data
);

	logic [ofw_pkg::COEF_W-1:0]  coef_s1;
	ofw_pkg::iss_t               meta_s1;
	ofw_pkg::iss_t               meta_s2;
	logic signed [33:0]          prod_s2;
	logic signed [16:0]          coef17;
	logic signed [33:0]          rnd;
	logic signed [ofw_pkg::SMP_W-1:0] sat;
	logic                        out_valid_q;

	assign adv       = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	ofw_coef_ram #(
		.DEPTH (FRAME_MAX),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (issue.valid),
		.raddr (raddr),
		.rdata (coef_s1)
	);

	assign coef17 = $signed({1'b0, coef_s1});
	assign rnd    = (prod_s2 + 34'sd16384) >>> 15;

	always_comb begin
		if (rnd > 34'sd32767) begin
			sat = 16'sh7fff;
		end else if (rnd < -34'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = rnd[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1.valid <= 1'b0;
			meta_s2.valid <= 1'b0;
			out_valid_q   <= 1'b0;
		end else if (adv) begin
			meta_s1                 <= issue;
			meta_s2                 <= meta_s1;
			out_valid_q             <= meta_s2.valid;
			prod_s2                 <= 34'(meta_s1.sample) * 34'(coef17);
			out_data.frame_number   <= meta_s2.frame_number;
			out_data.position       <= meta_s2.position;
			out_data.windowed_value <= sat;
			out_data.last           <= meta_s2.last;
		end
	end

endmodule

// ===== hdl/overlapped_frame_windowing_unit.sv =====
// Top level of the overlapped frame windowing unit with its register port.
//
// Input channel (in_valid/in_stall/in_data) takes two kinds of item: a load
// item writes one unsigned Q1.15 window coefficient, a sample item is
// windowed once for every open frame holding it (at most MAX_OVERLAP, newest).
// Output channel (out_valid/out_stall/out_data) returns one item per frame,
// oldest frame first, with last set on the final one for each sample.
// A load item writes the table as it is accepted. A sample item holds the
// input while the sequencer accepts it, forms the start position, then
// steps through the frames started so far (capped at MAX_OVERLAP), issuing
// one coefficient read from the single read port of the table for each
// frame that holds the sample. Each result passes the memory read, the
// multiply, then round and saturate into the output register.
// While out_stall is high and a result waits, the whole read/multiply
// pipeline holds; the sequencer holds its next read and resumes afterwards.
// Reset clears hop position, frame counter and frame count, and sets
// frame_length to 480 and hop to 160. The coefficient table is not
// cleared: every entry used must be loaded first.
// Registers: frame_length at 0x0, hop at 0x4; write them only while idle, the block does not enforce it.
module overlapped_frame_windowing_unit #(
	parameter int FRAME_MAX   = 1024,
	parameter int MAX_OVERLAP = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ofw_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ofw_pkg::out_t  out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int AW = $clog2(FRAME_MAX);

	logic [ofw_pkg::CFG_W-1:0]  frame_length_q;
	logic [ofw_pkg::CFG_W-1:0]  hop_q;
	logic                       reg_wr;
	ofw_pkg::cfg_t              cfg;
	ofw_pkg::iss_t              issue;
	logic [AW-1:0]              raddr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [ofw_pkg::COEF_W-1:0] wr_data;
	logic                       adv;
	logic                       busy;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= ofw_pkg::FRAME_LENGTH_RST;
			hop_q          <= ofw_pkg::HOP_RST;
		end else if (reg_wr) begin
			case (paddr[2])
				ofw_pkg::REG_FRAME_LENGTH: frame_length_q <= pwdata[ofw_pkg::CFG_W-1:0];
				ofw_pkg::REG_HOP:          hop_q          <= pwdata[ofw_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ofw_pkg::REG_FRAME_LENGTH: prdata = 32'(frame_length_q);
			ofw_pkg::REG_HOP:          prdata = 32'(hop_q);
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		if (frame_length_q == '0) begin
			cfg.flen = ofw_pkg::CFG_W'(1);
		end else if (32'(frame_length_q) > FRAME_MAX) begin
			cfg.flen = ofw_pkg::CFG_W'(FRAME_MAX);
		end else begin
			cfg.flen = frame_length_q;
		end
		if (hop_q == '0) begin
			cfg.hop = ofw_pkg::CFG_W'(1);
		end else if (32'(hop_q) > ofw_pkg::HOP_LIMIT) begin
			cfg.hop = ofw_pkg::CFG_W'(ofw_pkg::HOP_LIMIT);
		end else begin
			cfg.hop = hop_q;
		end
	end

	assign in_stall = busy;

	ofw_seq #(
		.FRAME_MAX   (FRAME_MAX),
		.MAX_OVERLAP (MAX_OVERLAP),
		.AW          (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.busy     (busy),
		.cfg      (cfg),
		.adv      (adv),
		.issue    (issue),
		.raddr    (raddr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	ofw_mac #(
		.FRAME_MAX (FRAME_MAX),
		.AW        (AW)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.raddr     (raddr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_issue_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> busy)
		else $error("coefficient read issued while sequencer idle");

	a_read_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> (32'(raddr) < 32'(cfg.flen)))
		else $error("coefficient read beyond frame length");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(issue.valid && issue.last) |=> (!issue.valid && !busy))
		else $error("read issued after last frame of a sample");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!busy && !issue.valid))
		else $error("coefficient load overlaps a sample");

endmodule

// ===== tb/sv/overlapped_frame_windowing_unit_tb.sv =====
// Self-checking testbench for the overlapped frame windowing unit.
`timescale 1ns / 100ps

module overlapped_frame_windowing_unit_tb;

	localparam int FRAME_MAX   = 1024;
	localparam int MAX_OVERLAP = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 40;

	typedef struct {
		int unsigned              offset;
		logic [ofw_pkg::FN_W-1:0] frame;
		int unsigned              started;
	} hop_state_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	ofw_pkg::in_t     in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	ofw_pkg::out_t    out_data;
	logic             psel      = 1'b0;
	logic             penable   = 1'b0;
	logic             pwrite    = 1'b0;
	logic [2:0]       paddr     = '0;
	logic [31:0]      pwdata    = '0;
	logic [31:0]      prdata;
	logic             pready;

	ofw_pkg::in_t     queued_items[$];
	ofw_pkg::out_t    due_results[$];
	logic [ofw_pkg::COEF_W-1:0] coef_table[FRAME_MAX];
	bit [FRAME_MAX-1:0] coef_loaded;
	logic [ofw_pkg::CFG_W-1:0] cfg_flen = ofw_pkg::FRAME_LENGTH_RST;
	logic [ofw_pkg::CFG_W-1:0] cfg_hop  = ofw_pkg::HOP_RST;
	hop_state_t       live_st  = '{0, '0, 0};
	hop_state_t       plan_st  = '{0, '0, 0};
	int               accepted_items = 0;
	int               cycle_count = 0;
	int               errors = 0;
	int               hold_left = 0;
	bit               pressure_req = 1'b0;
	bit               pressure_done = 1'b0;

	overlapped_frame_windowing_unit #(
		.FRAME_MAX(FRAME_MAX),
		.MAX_OVERLAP(MAX_OVERLAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// windows one sample against the open frames, oldest frame first
	function automatic int window_sample(inout hop_state_t st,
			input logic signed [ofw_pkg::SMP_W-1:0] smp,
			output ofw_pkg::out_t res [MAX_OVERLAP]);
		int unsigned flen;
		int unsigned h;
		int unsigned pos;
		int n;
		longint prod;
		flen = (cfg_flen == 0) ? 1 : ((cfg_flen > FRAME_MAX) ? FRAME_MAX : cfg_flen);
		h = (cfg_hop == 0) ? 1 :
			((cfg_hop > ofw_pkg::HOP_LIMIT) ? ofw_pkg::HOP_LIMIT : cfg_hop);
		n = 0;
		if (st.offset >= h)
			st.offset = 0;
		if (st.offset == 0) begin
			if (st.started > 0)
				st.frame = st.frame + ofw_pkg::FN_W'(1);
			if (st.started < MAX_OVERLAP)
				st.started++;
		end
		for (int j = int'(st.started) - 1; j >= 0; j--) begin
			pos = st.offset + j * h;
			if (pos < flen) begin
				prod = (longint'(smp) *
					longint'(coef_table[pos[ofw_pkg::IDX_W-1:0]]) + 16384) >>> 15;
				if (prod > 32767)
					prod = 32767;
				else if (prod < -32768)
					prod = -32768;
				res[n].frame_number   = st.frame - ofw_pkg::FN_W'(j);
				res[n].position       = ofw_pkg::POS_W'(pos);
				res[n].windowed_value = ofw_pkg::SMP_W'(prod);
				res[n].last           = 1'b0;
				n++;
			end
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		st.offset++;
		if (st.offset >= h)
			st.offset = 0;
		return n;
	endfunction

	function automatic logic [ofw_pkg::COEF_W-1:0] any_coef();
		if ($urandom_range(7) == 0)
			return ofw_pkg::COEF_W'($urandom_range(65535, 32769));
		return ofw_pkg::COEF_W'($urandom_range(32768, 0));
	endfunction

	function automatic logic signed [ofw_pkg::SMP_W-1:0] any_sample();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return '0;
			default: return ofw_pkg::SMP_W'($urandom);
		endcase
	endfunction

	function automatic void queue_load(input int idx,
			input logic [ofw_pkg::COEF_W-1:0] val);
		ofw_pkg::in_t it;
		it.command    = ofw_pkg::CMD_LOAD;
		it.sample     = ofw_pkg::SMP_W'($urandom);
		it.coef_index = ofw_pkg::IDX_W'(idx);
		it.coef_value = val;
		coef_loaded[idx] = 1'b1;
		queued_items = {queued_items, it};
	endfunction

	// queues a sample, first loading any coefficient it will read that was never written
	function automatic void queue_sample(input logic signed [ofw_pkg::SMP_W-1:0] smp);
		ofw_pkg::in_t it;
		ofw_pkg::out_t res [MAX_OVERLAP];
		int n;
		n = window_sample(plan_st, smp, res);
		for (int i = 0; i < n; i++)
			if (!coef_loaded[res[i].position])
				queue_load(int'(res[i].position), any_coef());
		it.command    = ofw_pkg::CMD_SAMPLE;
		it.sample     = smp;
		it.coef_index = ofw_pkg::IDX_W'($urandom);
		it.coef_value = ofw_pkg::COEF_W'($urandom);
		queued_items = {queued_items, it};
	endfunction

	task automatic drain();
		while (queued_items.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [ofw_pkg::CFG_W-1:0] flen,
			input logic [ofw_pkg::CFG_W-1:0] hop);
		drain();
		repeat (SETTLE) @(posedge clk);
		apb_write({ofw_pkg::REG_FRAME_LENGTH, 2'b00}, 32'(flen));
		cfg_flen = flen;
		apb_write({ofw_pkg::REG_HOP, 2'b00}, 32'(hop));
		cfg_hop = hop;
		plan_st = live_st;
	endtask

	// input driver and predictor
	always @(posedge clk or negedge arst_n) begin
		ofw_pkg::out_t res [MAX_OVERLAP];
		int n;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				accepted_items <= accepted_items + 1;
				if (in_data.command == ofw_pkg::CMD_LOAD) begin
					coef_table[in_data.coef_index] = in_data.coef_value;
				end else begin
					n = window_sample(live_st, in_data.sample, res);
					for (int i = 0; i < n; i++)
						due_results = {due_results, res[i]};
				end
			end
			if (!in_valid || !in_stall) begin
				if (queued_items.size() != 0 &&
						((accepted_items >= 100 && accepted_items < 140) ||
						$urandom_range(99) >= 13)) begin
					in_valid <= 1'b1;
					in_data  <= queued_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall     <= 1'b0;
			hold_left     <= 0;
			pressure_done <= 1'b0;
		end else if (pressure_req && !pressure_done) begin
			out_stall     <= 1'b1;
			hold_left     <= 400;
			pressure_done <= 1'b1;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= !(accepted_items >= 100 && accepted_items < 140) &&
				($urandom_range(99) < 13);
		end
	end

	// result checker
	always @(posedge clk) begin
		ofw_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: frame %0d position %0d value %0d",
					out_data.frame_number, out_data.position, out_data.windowed_value);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (out_data.frame_number !== want.frame_number) begin
					$error("frame_number: expected %0d, got %0d",
						want.frame_number, out_data.frame_number);
					errors++;
				end
				if (out_data.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, out_data.position);
					errors++;
				end
				if (out_data.windowed_value !== want.windowed_value) begin
					$error("windowed_value: expected %0d, got %0d",
						want.windowed_value, out_data.windowed_value);
					errors++;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_data.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int flen;
		coef_loaded = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// rounding, saturation, coefficient above 1.0, reload mid-stream
		set_config(ofw_pkg::CFG_W'(4), ofw_pkg::CFG_W'(2));
		queue_load(0, 16'h8000);
		queue_load(1, 16'hFFFF);
		queue_load(2, 16'h4000);
		queue_load(3, 16'h0001);
		queue_sample(16'h8000);
		queue_sample(16'h7FFF);
		queue_sample(16'h0001);
		queue_sample(16'hFFFF);
		queue_sample(16'h8000);
		queue_load(2, 16'h0000);
		queue_sample(16'h5555);
		queue_sample(16'hAAAA);
		queue_sample(16'h0000);
		queue_sample(16'h7FFF);
		queue_sample(16'hFFFF);
		queue_sample(16'h8000);

		// hop longer than frame, leaves offset inside the hop
		set_config(ofw_pkg::CFG_W'(3), ofw_pkg::CFG_W'(5));
		repeat (8) queue_sample(any_sample());

		// zero registers act as one; offset past new hop starts a frame
		set_config(ofw_pkg::CFG_W'(0), ofw_pkg::CFG_W'(0));
		repeat (6) queue_sample(any_sample());

		// registers above the limits
		set_config(ofw_pkg::CFG_W'(2047), ofw_pkg::CFG_W'(2047));
		repeat (6) queue_sample(any_sample());

		set_config(ofw_pkg::CFG_W'(1024), ofw_pkg::CFG_W'(1));
		repeat (10) queue_sample(any_sample());

		// full overlap while the output is held off
		set_config(ofw_pkg::CFG_W'(16), ofw_pkg::CFG_W'(2));
		pressure_req = 1'b1;
		repeat (14) queue_sample(any_sample());

		for (int p = 0; p < 6; p++) begin
			flen = $urandom_range(24, 1);
			set_config(ofw_pkg::CFG_W'(flen), ofw_pkg::CFG_W'($urandom_range(flen + 4, 1)));
			repeat (22) begin
				if ($urandom_range(99) < 15)
					queue_load($urandom_range(FRAME_MAX - 1), any_coef());
				else
					queue_sample(any_sample());
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
